@@ rtl/fhe_pkg.sv @@
`default_nettype none

package fhe_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REPORT = 2'd2
  } fhe_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } fhe_state_e;

  localparam int unsigned OpBits = 2;

endpackage

`default_nettype wire

@@ rtl/fhe_store.sv @@
`default_nettype none

module fhe_store #(
  parameter int unsigned KEY_BITS   = 10,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [KEY_BITS-1:0]   waddr_i,
  input  wire logic [COUNT_BITS-1:0] wdata_i,
  input  wire logic [KEY_BITS-1:0]   raddr_i,
  output logic      [COUNT_BITS-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << KEY_BITS;

  logic [COUNT_BITS-1:0] mem_q [Depth];
  logic [COUNT_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/frequency_histogram_extremes.sv @@
// Channel  Direction  Handshake                Payload
// input    in         in_valid_i / in_stall_o  op_i, item_key_i
// output   out        out_valid_o / out_stall_i key_count_o, most_key_o, most_count_o,
//                                              least_key_o, least_count_o, any_present_o
//
// Add and query pass through four steps from one accepted item to the next: accept, memory read,
// count update with write back, and result load, which waits while the output is stalled;
// the registered memory read sets these steps. Report reads the memory once per key and passes
// each count through one shared maximum and minimum compare unit.
// After reset the memory is cleared one entry per cycle, all 2^KEY_BITS entries, with in_stall_o high.
// A finished result waits in the output register, and the next item is accepted meanwhile.

`default_nettype none

module frequency_histogram_extremes #(
  parameter int unsigned KEY_BITS   = 10,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            op_i,
  input  wire logic [KEY_BITS-1:0]   item_key_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [COUNT_BITS-1:0] key_count_o,
  output logic      [KEY_BITS-1:0]   most_key_o,
  output logic      [COUNT_BITS-1:0] most_count_o,
  output logic      [KEY_BITS-1:0]   least_key_o,
  output logic      [COUNT_BITS-1:0] least_count_o,
  output logic                       any_present_o
);

  import fhe_pkg::*;

  localparam logic [KEY_BITS-1:0]   KeyLast  = {KEY_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  fhe_state_e state_q, state_d;

  logic [KEY_BITS-1:0]   idx_q;
  logic                  out_valid_q;
  logic                  any_q;
  logic                  scan_hot_q;
  logic                  lo_vld_q;

  logic [OpBits-1:0]     op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [KEY_BITS-1:0]   scan_key_q;
  logic [COUNT_BITS-1:0] res_count_q;
  logic [KEY_BITS-1:0]   hi_key_q;
  logic [COUNT_BITS-1:0] hi_cnt_q;
  logic [KEY_BITS-1:0]   lo_key_q;
  logic [COUNT_BITS-1:0] lo_cnt_q;

  logic [COUNT_BITS-1:0] key_count_q;
  logic [KEY_BITS-1:0]   most_key_q;
  logic [COUNT_BITS-1:0] most_count_q;
  logic [KEY_BITS-1:0]   least_key_q;
  logic [COUNT_BITS-1:0] least_count_q;
  logic                  any_present_q;

  logic                  in_take;
  logic                  out_free;
  logic                  load_out;
  logic                  mem_we;
  logic [KEY_BITS-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [KEY_BITS-1:0]   mem_raddr;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] inc_count;
  logic                  is_report;
  logic                  take_hi;
  logic                  take_lo;

  fhe_store #(
    .KEY_BITS  (KEY_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(rd_data)
  );

  assign in_take   = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign inc_count = (rd_data == CountMax) ? rd_data : rd_data + COUNT_BITS'(1);
  assign is_report = (op_q == OP_REPORT);
  assign take_hi   = scan_hot_q && (rd_data != '0) && (rd_data > hi_cnt_q);
  assign take_lo   = scan_hot_q && (rd_data != '0) && (!lo_vld_q || (rd_data < lo_cnt_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (idx_q == KeyLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if ((op_i == OP_ADD) || (op_i == OP_QUERY)) begin
            state_d = ST_LOOKUP;
          end else if (op_i == OP_REPORT) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_LOOKUP: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_FINISH;
      ST_SCAN: begin
        if (idx_q == KeyLast) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = key_q;
    mem_wdata  = inc_count;
    mem_raddr  = key_q;
    load_out   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = '0;
      end
      ST_IDLE: in_stall_o = 1'b0;
      ST_UPDATE: mem_we = (op_q == OP_ADD);
      ST_SCAN: mem_raddr = idx_q;
      ST_FINISH: load_out = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      any_q       <= 1'b0;
      scan_hot_q  <= 1'b0;
      lo_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_hot_q <= (state_q == ST_SCAN);
      if ((state_q == ST_CLEAR) || (state_q == ST_SCAN)) begin
        idx_q <= idx_q + KEY_BITS'(1);
      end else if (in_take) begin
        idx_q <= '0;
      end
      if (in_take) begin
        lo_vld_q <= 1'b0;
      end else if (take_lo) begin
        lo_vld_q <= 1'b1;
      end
      if ((state_q == ST_UPDATE) && (op_q == OP_ADD)) begin
        any_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_key_q <= idx_q;
    if (in_take) begin
      op_q        <= op_i;
      key_q       <= item_key_i;
      res_count_q <= '0;
      hi_key_q    <= '0;
      hi_cnt_q    <= '0;
      lo_key_q    <= '0;
      lo_cnt_q    <= '0;
    end else begin
      if (state_q == ST_UPDATE) begin
        res_count_q <= (op_q == OP_ADD) ? inc_count : rd_data;
      end
      if (take_hi) begin
        hi_key_q <= scan_key_q;
        hi_cnt_q <= rd_data;
      end
      if (take_lo) begin
        lo_key_q <= scan_key_q;
        lo_cnt_q <= rd_data;
      end
    end
    if (load_out) begin
      key_count_q   <= res_count_q;
      most_key_q    <= is_report && any_q ? hi_key_q : '0;
      most_count_q  <= is_report && any_q ? hi_cnt_q : '0;
      least_key_q   <= is_report && any_q ? lo_key_q : '0;
      least_count_q <= is_report && any_q ? lo_cnt_q : '0;
      any_present_q <= is_report && any_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_count_o   = key_count_q;
  assign most_key_o    = most_key_q;
  assign most_count_o  = most_count_q;
  assign least_key_o   = least_key_q;
  assign least_count_o = least_count_q;
  assign any_present_o = any_present_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("A result appeared without the sequencer finishing an item.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_hot_q |-> $past(state_q == ST_SCAN))
    else $error("Scan data was compared outside a report scan.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(any_q))
    else $error("The presence flag dropped after an add.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_vld_q |-> ((lo_cnt_q != '0) && (hi_cnt_q >= lo_cnt_q)))
    else $error("The running minimum is zero or exceeds the running maximum.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (mem_we && !out_valid_o))
    else $error("The clearing pass skipped a write or overlapped a result.");

endmodule

`default_nettype wire
